### rtl/rsmg_pkg.sv
// Shared types, codes and the diffusion tap table for the round subkey matrix generator.
// No dependencies; used by every module in rtl/.
package rsmg_pkg;

   localparam int DIM_BITS   = 3;
   localparam int ELEM_BITS  = 6;
   localparam int TAP_BITS   = 4;

   typedef enum logic [1:0] {
      ACT_LOAD_R   = 2'd0,
      ACT_LOAD_T   = 2'd1,
      ACT_GENERATE = 2'd2,
      ACT_UNUSED   = 2'd3
   } action_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [2:0]  row;
      logic [2:0]  col;
      logic [63:0] value;
   } req_type;

   typedef struct packed {
      logic [5:0]  word_index;
      logic [63:0] subkey_word;
      logic        last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD,
      ST_OP,
      ST_MUL,
      ST_ACC,
      ST_WR,
      ST_WHT_RD,
      ST_WHT_WR,
      ST_DIF_RD,
      ST_DIF_ACC,
      ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      PH_P,      // P = R * T
      PH_S,      // S = (T - R^T)^T (R + T^T)^T
      PH_M,      // M += S * P
      PH_WHITE,  // subkey ^= M, column-major
      PH_DIFF    // XOR diffusion and emit
   } phase_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_LOAD_R,
      DP_LOAD_T,
      DP_OPER,
      DP_MUL,
      DP_ACC,
      DP_WRITE,
      DP_WHITEN,
      DP_DIF_ACC,
      DP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type             op;
      phase_type             phase;
      logic [DIM_BITS-1:0]   i;
      logic [DIM_BITS-1:0]   j;
      logic [DIM_BITS-1:0]   k;
      logic [ELEM_BITS-1:0]  n;
      logic [TAP_BITS-1:0]   t;
      logic                  first;
   } cmd_type;

   localparam logic [4:0] DIFF_TAPS [32][16] = '{
      '{24, 8, 6, 1, 9, 4, 10, 3, 26, 2, 5, 15, 17, 13, 23, 12},
      '{19, 11, 22, 14, 25, 31, 7, 0, 30, 21, 28, 20, 18, 27, 29, 16},
      '{4, 18, 10, 26, 1, 22, 30, 21, 20, 5, 23, 12, 17, 6, 3, 25},
      '{11, 19, 24, 16, 0, 7, 28, 13, 29, 14, 2, 15, 27, 8, 31, 9},
      '{21, 13, 28, 4, 7, 24, 25, 9, 16, 5, 6, 19, 23, 31, 27, 1},
      '{15, 3, 11, 2, 12, 20, 17, 30, 10, 22, 8, 0, 18, 26, 29, 14},
      '{16, 24, 21, 25, 18, 10, 30, 22, 0, 6, 27, 1, 23, 4, 28, 3},
      '{12, 20, 14, 31, 15, 2, 9, 8, 29, 11, 5, 19, 26, 13, 17, 7},
      '{7, 31, 8, 24, 2, 9, 3, 22, 14, 6, 4, 20, 27, 17, 26, 21},
      '{19, 23, 15, 28, 5, 0, 1, 10, 25, 30, 13, 12, 18, 16, 29, 11},
      '{25, 9, 30, 22, 14, 3, 10, 18, 12, 4, 26, 21, 27, 24, 8, 28},
      '{0, 17, 1, 19, 11, 13, 5, 7, 29, 15, 6, 20, 16, 31, 23, 2},
      '{9, 17, 13, 5, 7, 2, 28, 30, 11, 4, 24, 0, 26, 23, 16, 22},
      '{12, 20, 27, 19, 8, 6, 21, 25, 3, 10, 31, 1, 18, 14, 29, 15},
      '{7, 3, 11, 30, 28, 18, 10, 25, 1, 24, 16, 22, 26, 9, 13, 8},
      '{20, 12, 21, 23, 31, 15, 6, 2, 29, 19, 4, 0, 14, 17, 27, 5},
      '{7, 31, 8, 24, 2, 9, 3, 22, 14, 6, 4, 20, 27, 17, 26, 21},
      '{19, 23, 15, 28, 5, 0, 1, 10, 25, 30, 13, 12, 18, 16, 29, 11},
      '{25, 9, 30, 22, 14, 3, 10, 18, 12, 4, 26, 21, 27, 24, 8, 28},
      '{0, 17, 1, 19, 11, 13, 5, 7, 29, 15, 6, 20, 16, 31, 23, 2},
      '{9, 17, 13, 5, 7, 2, 28, 30, 11, 4, 24, 0, 26, 23, 16, 22},
      '{12, 20, 27, 19, 8, 6, 21, 25, 3, 10, 31, 1, 18, 14, 29, 15},
      '{7, 3, 11, 30, 28, 18, 10, 25, 1, 24, 16, 22, 26, 9, 13, 8},
      '{20, 12, 21, 23, 31, 15, 6, 2, 29, 19, 4, 0, 14, 17, 27, 5},
      '{31, 7, 23, 6, 10, 2, 5, 8, 15, 24, 9, 12, 16, 27, 14, 30},
      '{0, 4, 20, 13, 1, 22, 26, 3, 28, 25, 17, 21, 18, 11, 29, 19},
      '{18, 10, 2, 15, 8, 28, 25, 3, 21, 9, 14, 30, 16, 7, 31, 13},
      '{17, 1, 22, 27, 19, 0, 4, 5, 29, 20, 24, 12, 11, 23, 26, 6},
      '{27, 2, 4, 13, 5, 6, 17, 25, 19, 9, 7, 1, 14, 26, 11, 10},
      '{28, 12, 16, 24, 0, 31, 21, 30, 8, 3, 23, 22, 18, 15, 29, 20},
      '{13, 5, 3, 19, 25, 8, 18, 28, 22, 7, 11, 10, 14, 2, 17, 31},
      '{21, 6, 30, 12, 20, 24, 23, 26, 29, 0, 9, 1, 15, 27, 16, 4}
   };

endpackage

### rtl/rsmg_ctrl.sv
// Sequencer for the round subkey matrix generator: state, phase and loop counters.
// Depends on rsmg_pkg; drives rsmg_datapath through cmd_type.
module rsmg_ctrl
   import rsmg_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   state_type             state_ff, state_in;
   phase_type             phase_ff, phase_in;
   logic [DIM_BITS-1:0]   i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [ELEM_BITS-1:0]  n_ff, n_in;
   logic [TAP_BITS-1:0]   t_ff, t_in;
   logic                  gen_once_ff, gen_once_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         phase_ff    <= PH_P;
         i_ff        <= '0;
         j_ff        <= '0;
         k_ff        <= '0;
         n_ff        <= '0;
         t_ff        <= '0;
         gen_once_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         phase_ff    <= phase_in;
         i_ff        <= i_in;
         j_ff        <= j_in;
         k_ff        <= k_in;
         n_ff        <= n_in;
         t_ff        <= t_in;
         gen_once_ff <= gen_once_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      k_in        = k_ff;
      n_in        = n_ff;
      t_in        = t_ff;
      gen_once_in = gen_once_ff;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      cmd.op      = DP_NOP;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (action_type'(req_data.action))
                  ACT_LOAD_R: cmd.op = DP_LOAD_R;
                  ACT_LOAD_T: cmd.op = DP_LOAD_T;
                  ACT_GENERATE: begin
                     phase_in = PH_P;
                     i_in     = '0;
                     j_in     = '0;
                     k_in     = '0;
                     state_in = ST_RD;
                  end
                  default: ;
               endcase
            end
         end
         ST_RD:  state_in = ST_OP;
         ST_OP: begin
            cmd.op   = DP_OPER;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.op   = DP_MUL;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.op = DP_ACC;
            if (k_ff == '1) begin
               state_in = ST_WR;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = ST_RD;
            end
         end
         ST_WR: begin
            cmd.op = DP_WRITE;
            k_in   = '0;
            j_in   = j_ff + 1'b1;
            if (j_ff == '1) begin
               i_in = i_ff + 1'b1;
            end
            state_in = ST_RD;
            if (i_ff == '1 && j_ff == '1) begin
               priority case (phase_ff)
                  PH_P: phase_in = PH_S;
                  PH_S: phase_in = PH_M;
                  default: begin
                     phase_in = PH_WHITE;
                     n_in     = '0;
                     state_in = ST_WHT_RD;
                  end
               endcase
            end
         end
         ST_WHT_RD: state_in = ST_WHT_WR;
         ST_WHT_WR: begin
            cmd.op = DP_WHITEN;
            n_in   = n_ff + 1'b1;
            if (n_ff == '1) begin
               phase_in = PH_DIFF;
               t_in     = '0;
               state_in = ST_DIF_RD;
            end else begin
               state_in = ST_WHT_RD;
            end
         end
         ST_DIF_RD: state_in = ST_DIF_ACC;
         ST_DIF_ACC: begin
            cmd.op = DP_DIF_ACC;
            if (t_ff == '1) begin
               state_in = ST_OUT;
            end else begin
               t_in     = t_ff + 1'b1;
               state_in = ST_DIF_RD;
            end
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.op = DP_EMIT;
               if (n_ff == '1) begin
                  gen_once_in = 1'b1;
                  state_in    = ST_IDLE;
               end else begin
                  n_in     = n_ff + 1'b1;
                  t_in     = '0;
                  state_in = ST_DIF_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      cmd.phase = phase_ff;
      cmd.i     = i_ff;
      cmd.j     = j_ff;
      cmd.k     = k_ff;
      cmd.n     = n_ff;
      cmd.t     = t_ff;
      cmd.first = ~gen_once_ff;
   end

endmodule

### rtl/rsmg_datapath.sv
// Matrix memories, split 64-bit multiply-accumulate and XOR diffusion datapath.
// Depends on rsmg_pkg; commanded by rsmg_ctrl.
module rsmg_datapath
   import rsmg_pkg::*;
(
   input  logic    clock,
   input  req_type req_data,
   input  cmd_type cmd,
   output rsp_type rsp_data
);

   logic [63:0] r_mem [64];
   logic [63:0] t_mem [64];
   logic [63:0] p_mem [64];
   logic [63:0] s_mem [64];
   logic [63:0] m_mem [64];
   logic [63:0] w_mem [64];
   logic [63:0] sk_mem [64];

   logic [63:0] r0_ff, r1_ff, t0_ff, t1_ff, p_rd_ff, s_rd_ff, m_rd_ff, w_rd_ff, sk_rd_ff;
   logic [63:0] a_ff, b_ff, ll_ff, acc_ff, x_ff;
   logic [31:0] lh_ff, hl_ff;

   logic [5:0] t0_addr, m_addr, w_addr, ij_addr;
   logic [5:0] load_addr;

   assign load_addr = {req_data.row, req_data.col};
   assign ij_addr   = {cmd.i, cmd.j};
   assign t0_addr   = (cmd.phase == PH_S) ? {cmd.k, cmd.i} : {cmd.k, cmd.j};
   assign m_addr    = (cmd.phase == PH_WHITE) ? {cmd.n[2:0], cmd.n[5:3]} : ij_addr;
   assign w_addr    = {cmd.n[5], DIFF_TAPS[cmd.n[4:0]][cmd.t]};

   // Reads run every cycle; addresses hold for the whole step.
   always_ff @(posedge clock) begin
      r0_ff    <= r_mem[{cmd.i, cmd.k}];
      r1_ff    <= r_mem[{cmd.j, cmd.k}];
      t0_ff    <= t_mem[t0_addr];
      t1_ff    <= t_mem[{cmd.k, cmd.j}];
      s_rd_ff  <= s_mem[{cmd.i, cmd.k}];
      p_rd_ff  <= p_mem[{cmd.k, cmd.j}];
      m_rd_ff  <= m_mem[m_addr];
      w_rd_ff  <= w_mem[w_addr];
      sk_rd_ff <= sk_mem[cmd.n];
   end

   always_ff @(posedge clock) begin
      if (cmd.op == DP_LOAD_R) begin
         r_mem[load_addr] <= req_data.value;
      end
      if (cmd.op == DP_LOAD_T) begin
         t_mem[load_addr] <= req_data.value;
      end
      if (cmd.op == DP_WRITE && cmd.phase == PH_P) begin
         p_mem[ij_addr] <= acc_ff;
      end
      if (cmd.op == DP_WRITE && cmd.phase == PH_S) begin
         s_mem[ij_addr] <= acc_ff;
      end
      if (cmd.op == DP_WRITE && cmd.phase == PH_M) begin
         m_mem[ij_addr] <= (cmd.first ? 64'd0 : m_rd_ff) + acc_ff;
      end
      if (cmd.op == DP_WHITEN) begin
         w_mem[cmd.n] <= (cmd.first ? 64'd0 : sk_rd_ff) ^ m_rd_ff;
      end
      if (cmd.op == DP_EMIT) begin
         sk_mem[cmd.n] <= x_ff;
      end
   end

   // Operand select, then three 32x32 partial products, then accumulate.
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         DP_OPER: begin
            priority case (cmd.phase)
               PH_P: begin
                  a_ff <= r0_ff;
                  b_ff <= t1_ff;
               end
               PH_S: begin
                  a_ff <= t0_ff - r0_ff;
                  b_ff <= r1_ff + t1_ff;
               end
               default: begin
                  a_ff <= s_rd_ff;
                  b_ff <= p_rd_ff;
               end
            endcase
         end
         DP_MUL: begin
            ll_ff <= {32'd0, a_ff[31:0]} * {32'd0, b_ff[31:0]};
            lh_ff <= 32'(a_ff[31:0] * b_ff[63:32]);
            hl_ff <= 32'(a_ff[63:32] * b_ff[31:0]);
         end
         DP_ACC: begin
            acc_ff <= ((cmd.k == '0) ? 64'd0 : acc_ff) + ll_ff + {lh_ff + hl_ff, 32'd0};
         end
         DP_DIF_ACC: begin
            x_ff <= ((cmd.t == '0) ? 64'd0 : x_ff) ^ w_rd_ff;
         end
         default: ;
      endcase
   end

   assign rsp_data.word_index  = cmd.n;
   assign rsp_data.subkey_word = x_ff;
   assign rsp_data.last        = (cmd.n == '1);

endmodule

### rtl/round_subkey_matrix_generator_core.sv
// Top level of the round subkey matrix generator.
// Depends on rsmg_pkg, rsmg_ctrl and rsmg_datapath.
//
// Loads of R (action 0) and T (action 1) write one 64-bit element each; action 3
// is accepted and ignored. A generate transaction (action 2) runs three 8x8x8
// matrix products (P = R*T, S = (T-R^T)^T (R+T^T)^T, M += S*P) on one shared
// multiply-accumulate unit, with the steps read, operand select, three 32x32
// partial products and accumulate for each MAC, plus a write step for each
// element. Whitening then passes over all 64 elements, and diffusion XORs 16
// taps per word, one memory read per tap, before each of the 64 result
// transactions is emitted; diffusion of a further word starts only once the
// current word is taken. The first generate after reset treats the accumulator
// and the subkey vector as zero, so no clearing pass is needed.
// A new request is taken only while the block is idle; the result register
// holds each subkey word until it is taken.
module round_subkey_matrix_generator_core
   import rsmg_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type cmd;

   rsmg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   rsmg_datapath u_datapath (
      .clock    (clock),
      .req_data (req_data),
      .cmd      (cmd),
      .rsp_data (rsp_data)
   );

endmodule
